// ===== hdl/waet_pkg.sv =====
// Shared types and constants for the weighted attribute entropy term block.
package waet_pkg;

    localparam int CNT_W = 17;
    localparam int ENT_W = 18;
    localparam int LOG_W = 37;
    localparam int PROD_W = 64;

    typedef struct packed {
        logic signed [7:0] attribute;
        logic signed [7:0] class_label;
        logic              last;
    } in_word_t;

    typedef struct packed {
        logic signed [ENT_W-1:0] entropy_value;
        logic [CNT_W-1:0]        positive_count;
        logic [CNT_W-1:0]        negative_count;
        logic [CNT_W-1:0]        sample_count;
    } out_word_t;

    typedef struct packed {
        logic [24:0] pos;
        logic [24:0] neg;
        logic [24:0] seen;
        logic        weighted;
    } set_word_t;

    typedef enum logic [0:0] {
        REG_TARGET = 1'b0,
        REG_MODE   = 1'b1
    } reg_index_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOG_SETUP,
        ST_LOG_ITER,
        ST_LOG_MUL,
        ST_SUB,
        ST_DIV,
        ST_WMUL,
        ST_WDIV,
        ST_ROUND,
        ST_OUT
    } back_state_t;

endpackage

// ===== hdl/waet_front.sv =====
// Front part: matches and counts samples, closes a set on the last word.
module waet_front #(
    parameter int MAX_SAMPLES = 65536
) (
    input  logic                clk,
    input  logic                rst_n,
    input  waet_pkg::in_word_t  in_word,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [7:0]          target_value,
    input  logic                weighted_mode,
    output waet_pkg::set_word_t set_word,
    output logic                set_valid,
    input  logic                set_ready
);
    import waet_pkg::*;

    logic [24:0] seen_reg, pos_reg, neg_reg;
    logic [24:0] seen_next, pos_next, neg_next;
    logic        take;
    logic        match;

    assign in_ready = set_ready || !in_word.last;
    assign take     = in_valid && in_ready;
    assign match    = !weighted_mode || (in_word.attribute == target_value);

    always_comb
    begin
        seen_next = seen_reg;
        pos_next  = pos_reg;
        neg_next  = neg_reg;
        if (seen_reg < 25'(MAX_SAMPLES))
        begin
            seen_next = seen_reg + 25'd1;
            if (match)
            begin
                if (in_word.class_label == 8'sd1)
                    pos_next = pos_reg + 25'd1;
                else
                    neg_next = neg_reg + 25'd1;
            end
        end
    end

    assign set_valid         = in_valid && in_word.last;
    assign set_word.pos      = pos_next;
    assign set_word.neg      = neg_next;
    assign set_word.seen     = seen_next;
    assign set_word.weighted = weighted_mode;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg <= '0;
            pos_reg  <= '0;
            neg_reg  <= '0;
        end
        else if (take)
        begin
            if (in_word.last)
            begin
                seen_reg <= '0;
                pos_reg  <= '0;
                neg_reg  <= '0;
            end
            else
            begin
                seen_reg <= seen_next;
                pos_reg  <= pos_next;
                neg_reg  <= neg_next;
            end
        end
    end

endmodule

// ===== hdl/waet_queue.sv =====
// Two-entry queue of closed sets between the front and back parts.
module waet_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  waet_pkg::set_word_t wr_word,
    input  logic                wr_valid,
    output logic                wr_ready,
    output waet_pkg::set_word_t rd_word,
    output logic                rd_valid,
    input  logic                rd_ready
);
    import waet_pkg::*;

    set_word_t   mem_reg [2];
    logic        wr_ptr_reg, rd_ptr_reg;
    logic [1:0]  fill_reg;

    assign wr_ready = fill_reg != 2'd2;
    assign rd_valid = fill_reg != 2'd0;
    assign rd_word  = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (wr_valid && wr_ready)
            mem_reg[wr_ptr_reg] <= wr_word;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= '0;
        end
        else
        begin
            if (wr_valid && wr_ready)
                wr_ptr_reg <= !wr_ptr_reg;
            if (rd_valid && rd_ready)
                rd_ptr_reg <= !rd_ptr_reg;
            fill_reg <= fill_reg + 2'(wr_valid && wr_ready) - 2'(rd_valid && rd_ready);
        end
    end

endmodule

// ===== hdl/waet_back.sv =====
// Back part: log2 by squaring, entropy, weighting and rounding of one set.
module waet_back #(
    parameter int FRAC_BITS = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  waet_pkg::set_word_t  set_word,
    input  logic                 set_valid,
    output logic                 set_ready,
    output waet_pkg::out_word_t  out_word,
    output logic                 out_valid,
    input  logic                 out_ready
);
    import waet_pkg::*;

    back_state_t       state_reg, state_next;
    set_word_t         set_reg;
    logic [1:0]        which_reg;
    logic [5:0]        step_reg;
    logic [4:0]        exp_reg;
    logic [32:0]       mant_reg;
    logic [31:0]       frac_reg;
    logic [PROD_W-1:0] acc_reg;
    logic [PROD_W-1:0] num_reg;
    logic [PROD_W-1:0] quo_reg;
    logic [PROD_W-1:0] rem_reg;
    logic [25:0]       den_reg;
    logic [6:0]        div_cnt_reg;
    out_word_t         out_reg;
    logic              out_valid_reg;

    logic [25:0]       n_sum;
    logic [24:0]       log_arg;
    logic [4:0]        lead_idx;
    logic [65:0]       sq;
    logic [32:0]       sq_m;
    logic [LOG_W-1:0]  log_val;
    logic [PROD_W-1:0] rem_sh;
    logic [PROD_W-1:0] mag;
    logic [PROD_W-1:0] neg_mag;

    assign n_sum = {1'b0, set_reg.pos} + {1'b0, set_reg.neg};

    always_comb
    begin
        unique case (which_reg)
            2'd0:    log_arg = n_sum[24:0];
            2'd1:    log_arg = set_reg.pos;
            default: log_arg = set_reg.neg;
        endcase
    end

    always_comb
    begin
        lead_idx = '0;
        for (int i = 1; i < 25; i++)
            if (log_arg[i])
                lead_idx = 5'(i);
    end

    assign sq      = {33'd0, mant_reg} * {33'd0, mant_reg};
    assign sq_m    = sq[63:31];
    assign log_val = {exp_reg, frac_reg};
    assign rem_sh  = {rem_reg[PROD_W-2:0], num_reg[PROD_W-1]};
    assign mag     = (quo_reg + (64'd1 << (31 - FRAC_BITS))) >> (32 - FRAC_BITS);
    assign neg_mag = (mag > 64'd131072) ? 64'd131072 : mag;

    assign set_ready = state_reg == ST_IDLE;
    assign out_word  = out_reg;
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:      if (set_valid) state_next = ST_LOG_SETUP;
            ST_LOG_SETUP: state_next = ST_LOG_ITER;
            ST_LOG_ITER:  if (step_reg == 6'd0) state_next = ST_LOG_MUL;
            ST_LOG_MUL:   state_next = (which_reg == 2'd2) ? ST_SUB : ST_LOG_SETUP;
            ST_SUB:       state_next = ST_DIV;
            ST_DIV:
                if (div_cnt_reg == 7'd0)
                    state_next = set_reg.weighted ? ST_WMUL : ST_ROUND;
            ST_WMUL:      state_next = ST_WDIV;
            ST_WDIV:      if (div_cnt_reg == 7'd0) state_next = ST_ROUND;
            ST_ROUND:     if (!out_valid_reg || out_ready) state_next = ST_OUT;
            ST_OUT:       state_next = ST_IDLE;
            default:      state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_OUT)
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:
            begin
                set_reg   <= set_word;
                which_reg <= 2'd0;
                acc_reg   <= '0;
                num_reg   <= '0;
            end
            ST_LOG_SETUP:
            begin
                exp_reg  <= lead_idx;
                mant_reg <= 33'(log_arg);
                frac_reg <= '0;
                step_reg <= 6'd32;
            end
            ST_LOG_ITER:
            begin
                if (step_reg == 6'd32)
                    mant_reg <= 33'({8'd0, log_arg} << (5'd31 - exp_reg));
                else if (sq_m[32])
                begin
                    frac_reg <= {frac_reg[30:0], 1'b1};
                    mant_reg <= {1'b0, sq_m[32:1]};
                end
                else
                begin
                    frac_reg <= {frac_reg[30:0], 1'b0};
                    mant_reg <= sq_m;
                end
                step_reg <= step_reg - 6'd1;
            end
            ST_LOG_MUL:
            begin
                if (log_arg == '0)
                    acc_reg <= acc_reg;
                else if (which_reg == 2'd0)
                    acc_reg <= PROD_W'({1'b0, log_arg} * log_val);
                else
                    num_reg <= num_reg + PROD_W'({1'b0, log_arg} * log_val);
                which_reg <= which_reg + 2'd1;
            end
            ST_SUB:
            begin
                num_reg     <= (num_reg >= acc_reg) ? '0 : acc_reg - num_reg;
                rem_reg     <= '0;
                quo_reg     <= '0;
                den_reg     <= (n_sum == '0) ? 26'd1 : n_sum;
                div_cnt_reg <= 7'd64;
            end
            ST_DIV, ST_WDIV:
            begin
                if (div_cnt_reg != 7'd0)
                begin
                    if (rem_sh >= PROD_W'(den_reg))
                    begin
                        rem_reg <= rem_sh - PROD_W'(den_reg);
                        quo_reg <= {quo_reg[PROD_W-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg <= rem_sh;
                        quo_reg <= {quo_reg[PROD_W-2:0], 1'b0};
                    end
                    num_reg     <= {num_reg[PROD_W-2:0], 1'b0};
                    div_cnt_reg <= div_cnt_reg - 7'd1;
                end
            end
            ST_WMUL:
            begin
                num_reg     <= PROD_W'(quo_reg[37:0] * n_sum);
                quo_reg     <= '0;
                rem_reg     <= '0;
                den_reg     <= {1'b0, set_reg.seen};
                div_cnt_reg <= 7'd64;
            end
            ST_ROUND:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_reg.positive_count <= set_reg.pos[CNT_W-1:0];
                    out_reg.negative_count <= set_reg.neg[CNT_W-1:0];
                    out_reg.sample_count   <= set_reg.seen[CNT_W-1:0];
                    if (n_sum == '0)
                        out_reg.entropy_value <= '0;
                    else if (set_reg.weighted)
                        out_reg.entropy_value <= ENT_W'(18'd0 - neg_mag[ENT_W-1:0]);
                    else
                        out_reg.entropy_value <= (mag > 64'd131071) ? 18'sd131071
                                                                    : ENT_W'(mag);
                end
            end
            default:
            begin
                acc_reg <= acc_reg;
            end
        endcase
    end

endmodule

// ===== hdl/weighted_attribute_entropy_term_core.sv =====
// Top level of the weighted attribute entropy term block.
// Throughput: one sample word per cycle, but the last word of a set stalls the input while
// the two-entry set queue is full; the back part takes a new set only once the last is done.
// Reset: rst_n clears counters, queue, registers (target 0, total mode) at once.
module weighted_attribute_entropy_term_core #(
    parameter int MAX_SAMPLES = 65536,
    parameter int FRAC_BITS   = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  waet_pkg::in_word_t  in_word,
    input  logic                in_valid,
    output logic                in_ready,
    output waet_pkg::out_word_t out_word,
    output logic                out_valid,
    input  logic                out_ready,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [0:0]          cfg_index,
    input  logic [7:0]          cfg_data
);
    import waet_pkg::*;

    logic [7:0] target_reg;
    logic       mode_reg;
    set_word_t  f_word, q_word;
    logic       f_valid, f_ready, q_valid, q_ready;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg <= '0;
            mode_reg   <= 1'b0;
        end
        else if (cfg_valid)
        begin
            unique case (reg_index_t'(cfg_index))
                REG_TARGET: target_reg <= cfg_data;
                REG_MODE:   mode_reg   <= cfg_data[0];
                default:    mode_reg   <= mode_reg;
            endcase
        end
    end

    waet_front #(.MAX_SAMPLES(MAX_SAMPLES)) u_front (
        .clk(clk), .rst_n(rst_n), .in_word(in_word), .in_valid(in_valid),
        .in_ready(in_ready), .target_value(target_reg), .weighted_mode(mode_reg),
        .set_word(f_word), .set_valid(f_valid), .set_ready(f_ready)
    );

    waet_queue u_queue (
        .clk(clk), .rst_n(rst_n), .wr_word(f_word), .wr_valid(f_valid),
        .wr_ready(f_ready), .rd_word(q_word), .rd_valid(q_valid), .rd_ready(q_ready)
    );

    waet_back #(.FRAC_BITS(FRAC_BITS)) u_back (
        .clk(clk), .rst_n(rst_n), .set_word(q_word), .set_valid(q_valid),
        .set_ready(q_ready), .out_word(out_word), .out_valid(out_valid),
        .out_ready(out_ready)
    );

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_word))
        else $error("result word dropped");
    a_last_stall: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_word.last && !f_ready |-> !in_ready)
        else $error("last word taken with full queue");
    a_counts: assert property (@(posedge clk) disable iff (!rst_n)
        f_valid |-> {1'b0, f_word.pos} + {1'b0, f_word.neg} <= {1'b0, f_word.seen})
        else $error("matched exceeds seen");

endmodule
